FILE: hdl/scc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the scratchpad check.
// Used by the result channel interface, the frame tracker and the top level.
`default_nettype none

package scc_pkg;

    localparam int unsigned FRAME_BYTES_DEF = 9;
    localparam logic [7:0]  FAULT_LIMIT_RST = 8'd3;
    localparam logic [7:0]  CRC_POLY_REFL   = 8'h8C;

    typedef logic signed [15:0] t_temp;

    typedef struct packed {
        logic  done;
        logic  good;
        t_temp temp;
    } t_frame_stat;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[k]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/scc_in_if.sv
// Input channel: one scratchpad byte per beat, with a frame start mark.
// Depends on nothing.
`default_nettype none

interface scc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

`default_nettype wire

FILE: hdl/scc_out_if.sv
// Result channel: held temperature, CRC status and fault flag per frame.
// Depends on scc_pkg for the temperature type.
`default_nettype none

interface scc_out_if;
    logic           valid;
    logic           ready;
    scc_pkg::t_temp temperature;
    logic           crc_good;
    logic           fault;

    modport source (output valid, output temperature, output crc_good, output fault,
                    input ready);
    modport sink   (input valid, input temperature, input crc_good, input fault,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/scc_frame_track.sv
// Frame tracker: byte position, running CRC-8 and the two temperature bytes.
// Depends on scc_pkg; reports frame completion as a t_frame_stat.
`default_nettype none

module scc_frame_track #(
    parameter int unsigned FRAME_BYTES = scc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_start,
    output scc_pkg::t_frame_stat    o_stat
);
    localparam int unsigned PosW = $clog2(FRAME_BYTES + 1);
    localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES);

    logic [PosW-1:0] r_pos, n_pos;
    logic [7:0]      r_crc, n_crc;
    logic [7:0]      r_lo, n_lo;
    logic [7:0]      r_hi, n_hi;
    logic [PosW-1:0] pos_eff, pos_inc;
    logic [7:0]      crc_eff, crc_new;
    logic            done;

    always_comb begin
        pos_eff = i_start ? '0 : r_pos;
        crc_eff = i_start ? 8'd0 : r_crc;
        crc_new = scc_pkg::crc8_byte(crc_eff, i_byte);
        pos_inc = pos_eff + PosW'(1);
        done    = i_take && (pos_inc >= LastPos);
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_lo    = r_lo;
        n_hi    = r_hi;
        if (i_take) begin
            n_pos = done ? '0 : pos_inc;
            n_crc = done ? 8'd0 : crc_new;
            if (pos_eff == '0) begin
                n_lo = i_byte;
            end else if (pos_eff == PosW'(1)) begin
                n_hi = i_byte;
            end
        end
        o_stat.done = done;
        o_stat.good = (crc_new == 8'd0);
        o_stat.temp = scc_pkg::t_temp'({r_hi, r_lo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= 8'd0;
            r_lo  <= 8'd0;
            r_hi  <= 8'd0;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
        end
    end
endmodule

`default_nettype wire

FILE: hdl/sensor_scratchpad_crc_check_unit.sv
// Scratchpad CRC check for a one-wire temperature sensor.
// Input channel i_in carries one scratchpad byte per beat, byte 0 first;
// frame_start marks byte 0 and drops any partly read frame. Frames may also
// follow each other without the mark. After the last byte of a frame one beat
// leaves on o_out: the held temperature (1/16 degree, two's complement), the
// CRC status of this frame and the fault flag.
// A good frame loads the temperature and clears the fault flag. A bad frame
// keeps the temperature and bumps the failure count until it reaches the
// fault_limit register (i_cfg_we / i_cfg_data); beyond that it sets the fault.
// Only reset clears the failure count; a good frame leaves it as it is.
// The result beat is valid in the cycle after the last byte is taken.
// One byte per cycle unless stalled; the CRC-8 byte update is combinational.
// A stalled receiver holds the result register and drops i_in.ready, so no
// byte is taken until the waiting result beat leaves.
// Reset clears the CRC, byte position, stored bytes, temperature, count and
// fault flag, and loads fault_limit with 3.
`default_nettype none

module sensor_scratchpad_crc_check_unit #(
    parameter int unsigned FRAME_BYTES = scc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    scc_in_if.sink          i_in,
    scc_out_if.source       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data
);
    scc_pkg::t_frame_stat stat;
    logic                 take;
    logic                 hold;

    logic [7:0]     r_limit, n_limit;
    logic [7:0]     r_fails, n_fails;
    scc_pkg::t_temp r_held,  n_held;
    logic           r_fault, n_fault;
    logic           r_oval,  n_oval;
    logic           r_ogood, n_ogood;

    assign hold       = r_oval && !o_out.ready;
    assign i_in.ready = !hold;
    assign take       = i_in.valid && i_in.ready;

    scc_frame_track #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.data_byte),
        .i_start (i_in.frame_start),
        .o_stat  (stat)
    );

    always_comb begin
        n_limit = i_cfg_we ? i_cfg_data : r_limit;
        n_fails = r_fails;
        n_held  = r_held;
        n_fault = r_fault;
        n_ogood = r_ogood;
        n_oval  = hold;
        if (stat.done) begin
            n_oval  = 1'b1;
            n_ogood = stat.good;
            if (stat.good) begin
                n_held  = stat.temp;
                n_fault = 1'b0;
            end else if (r_fails < r_limit) begin
                n_fails = r_fails + 8'd1;
            end else begin
                n_fault = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= scc_pkg::FAULT_LIMIT_RST;
            r_fails <= 8'd0;
            r_held  <= '0;
            r_fault <= 1'b0;
            r_oval  <= 1'b0;
            r_ogood <= 1'b0;
        end else begin
            r_limit <= n_limit;
            r_fails <= n_fails;
            r_held  <= n_held;
            r_fault <= n_fault;
            r_oval  <= n_oval;
            r_ogood <= n_ogood;
        end
    end

    assign o_out.valid       = r_oval;
    assign o_out.temperature = r_held;
    assign o_out.crc_good    = r_ogood;
    assign o_out.fault       = r_fault;
endmodule

`default_nettype wire

FILE: dv/scc_frame_checker.sv
`timescale 1ns / 100ps
// Result checker for the scratchpad CRC check unit: tracks bytes and frames,
// queues the result of each finished frame and compares every result beat.
// Depends on scc_pkg for the temperature type, the CRC polynomial and reset limit.
module scc_frame_checker #(
    parameter int unsigned FRAME_BYTES = scc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_start,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  scc_pkg::t_temp  i_out_temp,
    input  wire logic       i_out_good,
    input  wire logic       i_out_fault,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    output int              o_mismatches,
    output int              o_outstanding
);

    typedef struct {
        scc_pkg::t_temp temp;
        logic           good;
        logic           fault;
    } t_frame_result;

    t_frame_result  frame_results_q[$];
    t_frame_result  want;

    logic [7:0]     crc_run;
    logic [3:0]     pos;
    logic [7:0]     lo_byte;
    logic [7:0]     hi_byte;
    logic [7:0]     fail_tally;
    logic [7:0]     limit_reg;
    scc_pkg::t_temp last_temp;
    logic           fault_seen;

    int mismatch_cnt = 0;
    int pending_cnt = 0;

    assign o_mismatches  = mismatch_cnt;
    assign o_outstanding = pending_cnt;

    function automatic logic [7:0] crc8_lsb_first(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ scc_pkg::CRC_POLY_REFL) : (r >> 1);
        end
        return r;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic start);
        t_frame_result res;
        logic          good;
        if (start) begin
            pos     = 4'd0;
            crc_run = 8'd0;
        end
        if (pos == 4'd0) begin
            lo_byte = b;
        end else if (pos == 4'd1) begin
            hi_byte = b;
        end
        crc_run = crc8_lsb_first(crc_run, b);
        pos     = pos + 4'd1;
        if (pos >= FRAME_BYTES) begin
            good = (crc_run == 8'd0);
            if (good) begin
                last_temp  = {hi_byte, lo_byte};
                fault_seen = 1'b0;
            end else if (fail_tally < limit_reg) begin
                fail_tally = fail_tally + 8'd1;
            end else begin
                fault_seen = 1'b1;
            end
            pos       = 4'd0;
            crc_run   = 8'd0;
            res.temp  = last_temp;
            res.good  = good;
            res.fault = fault_seen;
            frame_results_q.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            crc_run    = 8'd0;
            pos        = 4'd0;
            lo_byte    = 8'd0;
            hi_byte    = 8'd0;
            fail_tally = 8'd0;
            limit_reg  = scc_pkg::FAULT_LIMIT_RST;
            last_temp  = '0;
            fault_seen = 1'b0;
            frame_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                limit_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (frame_results_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: result beat with none pending: %s %0d %0b %0b",
                                 $realtime, "temp/good/fault",
                                 i_out_temp, i_out_good, i_out_fault);
                    end
                end else begin
                    want = frame_results_q.pop_front();
                    if (i_out_temp !== want.temp || i_out_good !== want.good ||
                        i_out_fault !== want.fault) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: result mismatch: exp temp %0d good %0b fault %0b",
                                     $realtime, want.temp, want.good, want.fault);
                            $display("    got temp %0d good %0b fault %0b",
                                     i_out_temp, i_out_good, i_out_fault);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_byte(i_in_byte, i_in_start);
            end
        end
        pending_cnt = frame_results_q.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Bench top for the scratchpad CRC check unit: clock, reset, frame stimulus,
// result back-pressure, fault limit writes and the verdict.
// Depends on scc_pkg, the channel interfaces, the unit and scc_frame_checker.
module tb_top;

    localparam int FB = scc_pkg::FRAME_BYTES_DEF;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       cfg_we   = 1'b0;
    logic [7:0] cfg_data = 8'd0;

    bit steady_run     = 1'b0;
    int stall_requests = 0;
    int stall_served   = 0;
    int hold_left      = 0;
    int sent_bytes     = 0;
    bit aligned        = 1'b1;
    int mismatches;
    int outstanding;

    scc_in_if  in_ch ();
    scc_out_if out_ch ();

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sensor_scratchpad_crc_check_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    scc_frame_checker #(.FRAME_BYTES(FB)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_byte     (in_ch.data_byte),
        .i_in_start    (in_ch.frame_start),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_temp    (out_ch.temperature),
        .i_out_good    (out_ch.crc_good),
        .i_out_fault   (out_ch.fault),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic logic [7:0] crc_after(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ b[k]) begin
                r = (r >> 1) ^ scc_pkg::CRC_POLY_REFL;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_temp();
        logic [15:0] corners [4];
        corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        if ($urandom_range(3) == 0) begin
            return corners[$urandom_range(3)];
        end
        return 16'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start);
        while (!steady_run && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.frame_start <= start;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        sent_bytes++;
    endtask

    task automatic send_frame(input logic [15:0] temp, input bit corrupt, input logic first_start);
        logic [7:0] frame_bytes [FB];
        logic [7:0] c;
        int         k;
        frame_bytes[0] = temp[7:0];
        frame_bytes[1] = temp[15:8];
        for (k = 2; k < FB - 1; k++) begin
            frame_bytes[k] = 8'($urandom);
        end
        c = 8'd0;
        for (k = 0; k < FB - 1; k++) begin
            c = crc_after(c, frame_bytes[k]);
        end
        frame_bytes[FB - 1] = c;
        if (corrupt) begin
            k = $urandom_range(FB - 1);
            frame_bytes[k] ^= 8'($urandom_range(1, 255));
        end
        for (k = 0; k < FB; k++) begin
            send_byte(frame_bytes[k], (k == 0) ? first_start : 1'b0);
        end
        aligned = 1'b1;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, FB - 1);
        for (int k = 0; k < n; k++) begin
            send_byte(8'($urandom), $urandom_range(3) == 0);
        end
        aligned = 1'b0;
    endtask

    task automatic set_fault_limit(input logic [7:0] v);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_bytes);
        int stop_at;
        int pick;
        stop_at = sent_bytes + n_bytes;
        while (sent_bytes < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_frame(pick_temp(), 1'b0, aligned ? 1'($urandom_range(1)) : 1'b1);
            end else if (pick < 88) begin
                send_frame(pick_temp(), 1'b1, aligned ? 1'($urandom_range(1)) : 1'b1);
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_served != stall_requests) begin
                stall_served = stall_requests;
                hold_left    = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= steady_run ? 1'b1 : ($urandom_range(99) >= 7);
            end
        end
    end

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = 8'd0;
        in_ch.frame_start = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(16'h7FFF, 1'b0, 1'b1);
        send_frame(16'h8000, 1'b0, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_frame(16'hFFFF, 1'b0, 1'b1);
        repeat (4) send_frame(pick_temp(), 1'b1, 1'b1);
        send_frame(16'h0000, 1'b0, 1'b1);
        set_fault_limit(8'd0);
        send_frame(pick_temp(), 1'b1, 1'b1);
        send_frame(16'h0190, 1'b0, 1'b1);

        set_fault_limit(8'd255);
        run_random_phase(70);
        set_fault_limit(8'd8);
        stall_requests++;
        run_random_phase(70);
        set_fault_limit(8'd1);
        steady_run = 1'b1;
        run_random_phase(70);
        steady_run = 1'b0;
        set_fault_limit(8'd20);
        run_random_phase(50);
        set_fault_limit(8'($urandom));
        run_random_phase(50);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
